>>> rtl/ild_pkg.sv
`timescale 1ns / 1ps
// ild_pkg: shared types, opcode tables and decode functions for the length decoder
package ild_pkg;

  localparam int unsigned AddrW = 24;
  localparam int unsigned OpndW = 24;
  localparam int unsigned QueueDepth = 2;

  localparam logic [4:0] ModeRel8  = 5'd9;
  localparam logic [4:0] ModeRel16 = 5'd19;

  // accumulator immediates (follow M)
  localparam logic [7:0] OpOraImm = 8'h09;
  localparam logic [7:0] OpAndImm = 8'h29;
  localparam logic [7:0] OpEorImm = 8'h49;
  localparam logic [7:0] OpAdcImm = 8'h69;
  localparam logic [7:0] OpBitImm = 8'h89;
  localparam logic [7:0] OpLdaImm = 8'hA9;
  localparam logic [7:0] OpCmpImm = 8'hC9;
  localparam logic [7:0] OpSbcImm = 8'hE9;
  // index immediates (follow X)
  localparam logic [7:0] OpLdyImm = 8'hA0;
  localparam logic [7:0] OpLdxImm = 8'hA2;
  localparam logic [7:0] OpCpyImm = 8'hC0;
  localparam logic [7:0] OpCpxImm = 8'hE0;
  // indirect jumps with two operand bytes
  localparam logic [7:0] OpJmpInd  = 8'h6C;
  localparam logic [7:0] OpJmlInd  = 8'hDC;

  localparam logic [0:0] CfgAcc8   = 1'b0;
  localparam logic [0:0] CfgIndex8 = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [7:0]       opcode;
    logic [2:0]       len;
    logic [OpndW-1:0] operand;
  } instr_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam logic [6:0] MnemTab [256] = '{
    7'd0,7'd1,7'd2,7'd1,7'd3,7'd1,7'd4,7'd1,7'd5,7'd1,7'd4,7'd6,7'd3,7'd1,7'd4,7'd1,
    7'd7,7'd1,7'd1,7'd1,7'd8,7'd1,7'd4,7'd1,7'd9,7'd1,7'd10,7'd11,7'd8,7'd1,7'd4,7'd1,
    7'd12,7'd13,7'd14,7'd13,7'd15,7'd13,7'd16,7'd13,7'd17,7'd13,7'd16,7'd18,7'd15,7'd13,
    7'd16,7'd13,
    7'd19,7'd13,7'd13,7'd13,7'd15,7'd13,7'd16,7'd13,7'd20,7'd13,7'd21,7'd22,7'd15,7'd13,
    7'd16,7'd13,
    7'd23,7'd24,7'd25,7'd24,7'd26,7'd24,7'd27,7'd24,7'd28,7'd24,7'd27,7'd29,7'd30,7'd24,
    7'd27,7'd24,
    7'd31,7'd24,7'd24,7'd24,7'd32,7'd24,7'd27,7'd24,7'd33,7'd24,7'd34,7'd35,7'd30,7'd24,
    7'd27,7'd24,
    7'd36,7'd37,7'd38,7'd37,7'd39,7'd37,7'd40,7'd37,7'd41,7'd37,7'd40,7'd42,7'd30,7'd37,
    7'd40,7'd37,
    7'd43,7'd37,7'd37,7'd37,7'd39,7'd37,7'd40,7'd37,7'd44,7'd37,7'd45,7'd46,7'd30,7'd37,
    7'd40,7'd37,
    7'd47,7'd48,7'd49,7'd48,7'd50,7'd48,7'd51,7'd48,7'd52,7'd15,7'd53,7'd54,7'd50,7'd48,
    7'd51,7'd48,
    7'd55,7'd48,7'd48,7'd48,7'd50,7'd48,7'd51,7'd48,7'd56,7'd48,7'd57,7'd58,7'd39,7'd48,
    7'd39,7'd48,
    7'd59,7'd60,7'd61,7'd60,7'd59,7'd60,7'd61,7'd60,7'd62,7'd60,7'd63,7'd64,7'd59,7'd60,
    7'd61,7'd60,
    7'd65,7'd60,7'd60,7'd60,7'd59,7'd60,7'd61,7'd60,7'd66,7'd60,7'd67,7'd68,7'd59,7'd60,
    7'd61,7'd60,
    7'd69,7'd70,7'd71,7'd70,7'd69,7'd70,7'd21,7'd70,7'd72,7'd70,7'd73,7'd74,7'd69,7'd70,
    7'd21,7'd70,
    7'd75,7'd70,7'd70,7'd70,7'd76,7'd70,7'd21,7'd70,7'd77,7'd70,7'd78,7'd79,7'd30,7'd70,
    7'd21,7'd70,
    7'd80,7'd81,7'd82,7'd81,7'd80,7'd81,7'd10,7'd81,7'd83,7'd81,7'd84,7'd85,7'd80,7'd81,
    7'd10,7'd81,
    7'd86,7'd81,7'd81,7'd81,7'd87,7'd81,7'd10,7'd81,7'd88,7'd81,7'd89,7'd90,7'd12,7'd81,
    7'd10,7'd81
  };

  localparam logic [4:0] ModeTab [256] = '{
    5'd0,5'd1,5'd0,5'd2,5'd3,5'd3,5'd3,5'd4,5'd5,5'd0,5'd6,5'd5,5'd7,5'd7,5'd7,5'd8,
    5'd9,5'd10,5'd11,5'd12,5'd3,5'd13,5'd13,5'd14,5'd5,5'd15,5'd6,5'd5,5'd7,5'd16,5'd16,
    5'd17,
    5'd7,5'd1,5'd8,5'd2,5'd3,5'd3,5'd3,5'd4,5'd5,5'd0,5'd6,5'd5,5'd7,5'd7,5'd7,5'd8,
    5'd9,5'd10,5'd11,5'd12,5'd13,5'd13,5'd13,5'd14,5'd5,5'd15,5'd6,5'd5,5'd16,5'd16,5'd16,
    5'd17,
    5'd5,5'd1,5'd0,5'd2,5'd18,5'd3,5'd3,5'd4,5'd5,5'd0,5'd6,5'd5,5'd7,5'd7,5'd7,5'd8,
    5'd9,5'd10,5'd11,5'd12,5'd18,5'd13,5'd13,5'd14,5'd5,5'd15,5'd5,5'd5,5'd8,5'd16,5'd16,
    5'd17,
    5'd5,5'd1,5'd19,5'd2,5'd3,5'd3,5'd3,5'd4,5'd5,5'd0,5'd6,5'd5,5'd11,5'd7,5'd7,5'd8,
    5'd9,5'd10,5'd11,5'd12,5'd13,5'd13,5'd13,5'd14,5'd5,5'd15,5'd5,5'd5,5'd16,5'd16,5'd16,
    5'd17,
    5'd9,5'd1,5'd19,5'd2,5'd3,5'd3,5'd3,5'd4,5'd5,5'd0,5'd5,5'd5,5'd7,5'd7,5'd7,5'd8,
    5'd9,5'd10,5'd11,5'd12,5'd13,5'd13,5'd20,5'd14,5'd5,5'd15,5'd5,5'd5,5'd7,5'd16,5'd16,
    5'd17,
    5'd21,5'd1,5'd21,5'd2,5'd3,5'd3,5'd3,5'd4,5'd5,5'd0,5'd5,5'd5,5'd7,5'd7,5'd7,5'd8,
    5'd9,5'd10,5'd11,5'd12,5'd13,5'd13,5'd20,5'd14,5'd5,5'd15,5'd5,5'd5,5'd16,5'd16,5'd15,
    5'd17,
    5'd21,5'd1,5'd0,5'd2,5'd3,5'd3,5'd3,5'd4,5'd5,5'd0,5'd5,5'd5,5'd7,5'd7,5'd7,5'd8,
    5'd9,5'd10,5'd11,5'd12,5'd11,5'd13,5'd13,5'd14,5'd5,5'd15,5'd5,5'd5,5'd4,5'd16,5'd16,
    5'd17,
    5'd21,5'd1,5'd0,5'd2,5'd3,5'd3,5'd3,5'd4,5'd5,5'd0,5'd5,5'd5,5'd7,5'd7,5'd7,5'd8,
    5'd9,5'd10,5'd11,5'd12,5'd7,5'd13,5'd13,5'd14,5'd5,5'd15,5'd5,5'd5,5'd16,5'd16,5'd16,
    5'd17
  };

  // base length per addressing mode
  function automatic logic [2:0] mode_len(input logic [4:0] mode);
    logic [2:0] len;
    case (mode)
      5'd5, 5'd6:                                  len = 3'd1;
      5'd7, 5'd15, 5'd16, 5'd18, 5'd19:            len = 3'd3;
      5'd8, 5'd17:                                 len = 3'd4;
      default:                                     len = 3'd2;
    endcase
    return len;
  endfunction

  // bit n set: n operand bytes suit the mode
  function automatic logic [3:0] mode_fit(input logic [4:0] mode);
    logic [3:0] fit;
    case (mode)
      5'd0, 5'd11, 5'd21:               fit = 4'd6;
      5'd5, 5'd6:                       fit = 4'd15;
      5'd7, 5'd15, 5'd16, 5'd18, 5'd19: fit = 4'd4;
      5'd8, 5'd17:                      fit = 4'd8;
      default:                          fit = 4'd2;
    endcase
    return fit;
  endfunction

  function automatic logic [2:0] instr_len(input logic [7:0] op, input logic acc8,
                                           input logic idx8);
    logic [2:0] len;
    unique case (op) inside
      OpOraImm, OpAndImm, OpEorImm, OpAdcImm,
      OpBitImm, OpLdaImm, OpCmpImm, OpSbcImm: len = acc8 ? 3'd2 : 3'd3;
      OpLdyImm, OpLdxImm, OpCpyImm, OpCpxImm: len = idx8 ? 3'd2 : 3'd3;
      OpJmpInd, OpJmlInd:                     len = 3'd3;
      default:                                len = mode_len(ModeTab[op]);
    endcase
    return len;
  endfunction

endpackage

>>> rtl/instruction_length_decoder_top.sv
`timescale 1ns / 1ps
// instruction_length_decoder_top: 65816 instruction splitter, top level
// Takes one code byte per cycle while in_stall_o is low, with its 24-bit address,
// and cuts the stream into 65816 instructions; one result item comes out on the
// last byte of each instruction. Any byte may follow in the next cycle. The
// splitter writes the two-entry queue when the last byte is accepted, and the
// registered result stage takes the record from the queue when its output is
// not held by out_stall_i. The length of
// an instruction is fixed when its opcode arrives, so
// writes to the M/X flags (index 0 acc_8bit, index 1 index_8bit) only touch
// later opcodes. Input stall rises only when the queue is full, i.e. when the
// output side has been stalled long enough to back up.
module instruction_length_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic        cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  input  logic [23:0] byte_address_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] instr_address_o,
  output logic [7:0]  opcode_value_o,
  output logic [6:0]  mnemonic_index_o,
  output logic [4:0]  mode_code_o,
  output logic [2:0]  instr_length_o,
  output logic [23:0] operand_value_o,
  output logic [15:0] branch_target_o,
  output logic        target_valid_o,
  output logic        format_ok_o
);

  logic                   accept;
  logic                   push, pop;
  ild_pkg::instr_rec_t    push_rec, pop_rec;
  ild_pkg::queue_status_t q_status;

  // flags are plain registers, always writable
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status.full;
  assign accept      = in_valid_i && !in_stall_o;

  ild_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .code_byte_i    (code_byte_i),
    .byte_address_i (byte_address_i),
    .push_o         (push),
    .rec_o          (push_rec)
  );

  ild_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .status_o   (q_status)
  );

  ild_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_valid_i      (!q_status.empty),
    .rec_i            (pop_rec),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .instr_address_o  (instr_address_o),
    .opcode_value_o   (opcode_value_o),
    .mnemonic_index_o (mnemonic_index_o),
    .mode_code_o      (mode_code_o),
    .instr_length_o   (instr_length_o),
    .operand_value_o  (operand_value_o),
    .branch_target_o  (branch_target_o),
    .target_valid_o   (target_valid_o),
    .format_ok_o      (format_ok_o)
  );

endmodule

>>> rtl/ild_front.sv
`timescale 1ns / 1ps
// ild_front: byte splitter, gathers opcode and operand bytes into instruction records
module ild_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [0:0]                   cfg_index_i,
  input  logic                         cfg_data_i,
  input  logic                         accept_i,
  input  logic [7:0]                   code_byte_i,
  input  logic [ild_pkg::AddrW-1:0]    byte_address_i,
  output logic                         push_o,
  output ild_pkg::instr_rec_t          rec_o
);

  logic                      acc8_q, idx8_q;
  logic [1:0]                pos_q, pos_d;
  logic [2:0]                len_q, len_d;
  logic [7:0]                op_q, op_d;
  logic [ild_pkg::AddrW-1:0] addr_q, addr_d;
  logic [ild_pkg::OpndW-1:0] opnd_q, opnd_d;
  logic [ild_pkg::OpndW-1:0] opnd_new;
  logic [1:0]                pos_inc;
  logic [2:0]                op_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc8_q <= 1'b1;
      idx8_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ild_pkg::CfgAcc8:   acc8_q <= cfg_data_i;
        ild_pkg::CfgIndex8: idx8_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign op_len  = ild_pkg::instr_len(code_byte_i, acc8_q, idx8_q);
  assign pos_inc = pos_q + 2'd1;

  always_comb begin
    case (pos_q)
      2'd1:    opnd_new = opnd_q | {16'd0, code_byte_i};
      2'd2:    opnd_new = opnd_q | {8'd0, code_byte_i, 8'd0};
      default: opnd_new = opnd_q | {code_byte_i, 16'd0};
    endcase
  end

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    op_d   = op_q;
    addr_d = addr_q;
    opnd_d = opnd_q;
    push_o = 1'b0;
    rec_o  = '{addr: addr_q, opcode: op_q, len: len_q, operand: opnd_new};
    if (accept_i) begin
      if (pos_q == 2'd0) begin
        op_d   = code_byte_i;
        addr_d = byte_address_i;
        opnd_d = '0;
        len_d  = op_len;
        if (op_len <= 3'd1) begin
          push_o = 1'b1;
          rec_o  = '{addr: byte_address_i, opcode: code_byte_i, len: op_len, operand: '0};
        end else begin
          pos_d = 2'd1;
        end
      end else begin
        opnd_d = opnd_new;
        if (pos_inc == 2'd0 || {1'b0, pos_inc} >= len_q) begin
          push_o = 1'b1;
          pos_d  = 2'd0;
        end else begin
          pos_d = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      len_q  <= 3'd0;
      op_q   <= 8'd0;
      addr_q <= '0;
      opnd_q <= '0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      op_q   <= op_d;
      addr_q <= addr_d;
      opnd_q <= opnd_d;
    end
  end

  a_mid_needs_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd0 |-> len_q >= 3'd2) else $error("operand phase with short length");
  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd0 |-> {1'b0, pos_q} < len_q) else $error("byte position past length");
  a_push_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> pos_q == 2'd0) else $error("position not cleared after item");

endmodule

>>> rtl/ild_queue.sv
`timescale 1ns / 1ps
// ild_queue: two-entry record queue between the splitter and the result stage
module ild_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ild_pkg::instr_rec_t   push_rec_i,
  input  logic                  pop_i,
  output ild_pkg::instr_rec_t   pop_rec_o,
  output ild_pkg::queue_status_t status_o
);

  ild_pkg::instr_rec_t mem_q [ild_pkg::QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign status_o.full  = (count_q == 2'(ild_pkg::QueueDepth));
  assign status_o.empty = (count_q == 2'd0);
  assign pop_rec_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && status_o.empty)) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(ild_pkg::QueueDepth)) else $error("queue count out of range");

endmodule

>>> rtl/ild_back.sv
`timescale 1ns / 1ps
// ild_back: table lookup, branch target and format check into the output register
module ild_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rec_valid_i,
  input  ild_pkg::instr_rec_t       rec_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ild_pkg::AddrW-1:0] instr_address_o,
  output logic [7:0]                opcode_value_o,
  output logic [6:0]                mnemonic_index_o,
  output logic [4:0]                mode_code_o,
  output logic [2:0]                instr_length_o,
  output logic [ild_pkg::OpndW-1:0] operand_value_o,
  output logic [15:0]               branch_target_o,
  output logic                      target_valid_o,
  output logic                      format_ok_o
);

  logic        valid_q;
  logic [4:0]  mode;
  logic [15:0] offset;
  logic        is_rel;
  logic [1:0]  count;
  logic [3:0]  fit;

  assign pop_o = rec_valid_i && (!valid_q || !out_stall_i);
  assign mode  = ild_pkg::ModeTab[rec_i.opcode];
  assign count = 2'(rec_i.len - 3'd1);
  assign fit   = ild_pkg::mode_fit(mode);

  always_comb begin
    is_rel = 1'b1;
    if (mode == ild_pkg::ModeRel8) begin
      offset = {{8{rec_i.operand[7]}}, rec_i.operand[7:0]};
    end else if (mode == ild_pkg::ModeRel16) begin
      offset = rec_i.operand[15:0];
    end else begin
      offset = 16'd0;
      is_rel = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= rec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      instr_address_o  <= rec_i.addr;
      opcode_value_o   <= rec_i.opcode;
      mnemonic_index_o <= ild_pkg::MnemTab[rec_i.opcode];
      mode_code_o      <= mode;
      instr_length_o   <= rec_i.len;
      operand_value_o  <= rec_i.operand;
      branch_target_o  <= is_rel ? rec_i.addr[15:0] + {13'd0, rec_i.len} + offset : 16'd0;
      target_valid_o   <= is_rel;
      format_ok_o      <= fit[count];
    end
  end

  assign out_valid_o = valid_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_stall_i |-> !pop_o) else $error("pop while output held");
  a_target_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> target_valid_o == (mode_code_o == ild_pkg::ModeRel8 ||
                                   mode_code_o == ild_pkg::ModeRel16))
    else $error("target flag does not match mode");
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> instr_length_o >= 3'd1 && instr_length_o <= 3'd4)
    else $error("length out of range");

endmodule

>>> bench/instruction_length_decoder_top_tb.sv
`timescale 1ns / 1ps
// instruction_length_decoder_top_tb: self-checking bench for the 65816 instruction splitter
module instruction_length_decoder_top_tb;

  // decoded instruction as it should leave the block
  typedef struct {
    logic [23:0] addr;
    logic [7:0]  op;
    logic [6:0]  mnem;
    logic [4:0]  mode;
    logic [2:0]  len;
    logic [23:0] opnd;
    logic [15:0] target;
    logic        tvalid;
    logic        fmt_ok;
  } decoded_t;

  // mnemonic number per opcode, in order of first appearance
  localparam byte unsigned MnemOf [256] = '{
    0,1,2,1,3,1,4,1,5,1,4,6,3,1,4,1,
    7,1,1,1,8,1,4,1,9,1,10,11,8,1,4,1,
    12,13,14,13,15,13,16,13,17,13,16,18,15,13,16,13,
    19,13,13,13,15,13,16,13,20,13,21,22,15,13,16,13,
    23,24,25,24,26,24,27,24,28,24,27,29,30,24,27,24,
    31,24,24,24,32,24,27,24,33,24,34,35,30,24,27,24,
    36,37,38,37,39,37,40,37,41,37,40,42,30,37,40,37,
    43,37,37,37,39,37,40,37,44,37,45,46,30,37,40,37,
    47,48,49,48,50,48,51,48,52,15,53,54,50,48,51,48,
    55,48,48,48,50,48,51,48,56,48,57,58,39,48,39,48,
    59,60,61,60,59,60,61,60,62,60,63,64,59,60,61,60,
    65,60,60,60,59,60,61,60,66,60,67,68,59,60,61,60,
    69,70,71,70,69,70,21,70,72,70,73,74,69,70,21,70,
    75,70,70,70,76,70,21,70,77,70,78,79,30,70,21,70,
    80,81,82,81,80,81,10,81,83,81,84,85,80,81,10,81,
    86,81,81,81,87,81,10,81,88,81,89,90,12,81,10,81
  };

  // addressing mode per opcode
  localparam byte unsigned AddrModeOf [256] = '{
    0,1,0,2,3,3,3,4,5,0,6,5,7,7,7,8,
    9,10,11,12,3,13,13,14,5,15,6,5,7,16,16,17,
    7,1,8,2,3,3,3,4,5,0,6,5,7,7,7,8,
    9,10,11,12,13,13,13,14,5,15,6,5,16,16,16,17,
    5,1,0,2,18,3,3,4,5,0,6,5,7,7,7,8,
    9,10,11,12,18,13,13,14,5,15,5,5,8,16,16,17,
    5,1,19,2,3,3,3,4,5,0,6,5,11,7,7,8,
    9,10,11,12,13,13,13,14,5,15,5,5,16,16,16,17,
    9,1,19,2,3,3,3,4,5,0,5,5,7,7,7,8,
    9,10,11,12,13,13,20,14,5,15,5,5,7,16,16,17,
    21,1,21,2,3,3,3,4,5,0,5,5,7,7,7,8,
    9,10,11,12,13,13,20,14,5,15,5,5,16,16,15,17,
    21,1,0,2,3,3,3,4,5,0,5,5,7,7,7,8,
    9,10,11,12,11,13,13,14,5,15,5,5,4,16,16,17,
    21,1,0,2,3,3,3,4,5,0,5,5,7,7,7,8,
    9,10,11,12,7,13,13,14,5,15,5,5,16,16,16,17
  };

  localparam byte unsigned BaseLen [22] = '{2,2,2,2,2,1,1,3,4,2,2,2,2,2,2,3,3,4,3,3,2,2};
  localparam byte unsigned FitMask [22] = '{6,2,2,2,2,15,15,4,8,2,2,6,2,2,2,4,4,8,4,4,2,6};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic        cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  code_byte_i;
  logic [23:0] byte_address_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [23:0] instr_address_o;
  logic [7:0]  opcode_value_o;
  logic [6:0]  mnemonic_index_o;
  logic [4:0]  mode_code_o;
  logic [2:0]  instr_length_o;
  logic [23:0] operand_value_o;
  logic [15:0] branch_target_o;
  logic        target_valid_o;
  logic        format_ok_o;

  instruction_length_decoder_top uut (.*);

  // predictor copy of flags and splitter state
  logic        m_flag;
  logic        x_flag;
  int unsigned pos;
  logic [2:0]  need_len;
  logic [7:0]  cur_op;
  logic [23:0] cur_addr;
  logic [23:0] cur_opnd;

  decoded_t    pending_instrs[$];
  int          errors;
  int          send_idle_pct;
  int          stall_pct;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on run time
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver stall, random per cycle at the current phase's rate
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // length fixed at opcode time from the current flags
  function automatic logic [2:0] length_for(input logic [7:0] op);
    logic [2:0] len;
    case (op) inside
      ild_pkg::OpOraImm, ild_pkg::OpAndImm, ild_pkg::OpEorImm, ild_pkg::OpAdcImm,
      ild_pkg::OpBitImm, ild_pkg::OpLdaImm, ild_pkg::OpCmpImm,
      ild_pkg::OpSbcImm:                      len = m_flag ? 3'd2 : 3'd3;
      ild_pkg::OpLdyImm, ild_pkg::OpLdxImm, ild_pkg::OpCpyImm,
      ild_pkg::OpCpxImm:                      len = x_flag ? 3'd2 : 3'd3;
      ild_pkg::OpJmpInd, ild_pkg::OpJmlInd:   len = 3'd3;
      default:                                len = 3'(BaseLen[AddrModeOf[op]]);
    endcase
    return len;
  endfunction

  // immediates whose length follows a flag
  function automatic bit is_flag_op(input logic [7:0] op);
    bit hit;
    case (op) inside
      ild_pkg::OpOraImm, ild_pkg::OpAndImm, ild_pkg::OpEorImm, ild_pkg::OpAdcImm,
      ild_pkg::OpBitImm, ild_pkg::OpLdaImm, ild_pkg::OpCmpImm, ild_pkg::OpSbcImm,
      ild_pkg::OpLdyImm, ild_pkg::OpLdxImm, ild_pkg::OpCpyImm,
      ild_pkg::OpCpxImm: hit = 1'b1;
      default:           hit = 1'b0;
    endcase
    return hit;
  endfunction

  // build the result for the instruction that just finished
  function automatic decoded_t finish_instr();
    decoded_t    d;
    logic [31:0] off;
    d.addr   = cur_addr;
    d.op     = cur_op;
    d.mnem   = 7'(MnemOf[cur_op]);
    d.mode   = 5'(AddrModeOf[cur_op]);
    d.len    = need_len;
    d.opnd   = cur_opnd;
    d.tvalid = (d.mode == ild_pkg::ModeRel8) || (d.mode == ild_pkg::ModeRel16);
    off = (d.mode == ild_pkg::ModeRel8) ? {{24{cur_opnd[7]}}, cur_opnd[7:0]}
                                        : {{16{cur_opnd[15]}}, cur_opnd[15:0]};
    d.target = d.tvalid ? 16'(32'(cur_addr) + 32'(need_len) + off) : 16'd0;
    d.fmt_ok = FitMask[d.mode][2'(need_len - 3'd1)];
    return d;
  endfunction

  // advance the splitter model by one accepted byte
  function automatic void split_byte(input logic [7:0] b, input logic [23:0] a);
    if (pos == 0) begin
      cur_op   = b;
      cur_addr = a;
      cur_opnd = '0;
      need_len = length_for(b);
      if (need_len <= 3'd1) pending_instrs = {pending_instrs, finish_instr()};
      else pos = 1;
    end else begin
      cur_opnd = cur_opnd | (24'(b) << (8 * (pos - 1)));
      pos = (pos + 1) % 4;
      if (pos >= need_len || pos == 0) begin
        pos = 0;
        pending_instrs = {pending_instrs, finish_instr()};
      end
    end
  endfunction

  // idle per cycle at the current rate, then send one byte and wait for acceptance
  task automatic send_byte(input logic [7:0] b, input logic [23:0] a);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    code_byte_i    <= b;
    byte_address_i <= a;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    split_byte(b, a);
  endtask

  // opcode followed by as many random operand bytes as the instruction takes
  task automatic send_instr(input logic [7:0] op, input logic [23:0] a);
    send_byte(op, a);
    while (pos != 0) send_byte(8'($urandom), 24'($urandom));
  endtask

  task automatic send_instr_opnd(input logic [7:0] op, input logic [23:0] a,
                                 input logic [23:0] opnd);
    int k;
    k = 0;
    send_byte(op, a);
    while (pos != 0) begin
      send_byte(opnd[8*k +: 8], a + 24'(k + 1));
      k++;
    end
  endtask

  // wait until every expected result has come, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_instrs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_flag(input logic [0:0] idx, input logic val);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    if (idx == ild_pkg::CfgAcc8) m_flag = val;
    else x_flag = val;
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_v,
                             input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // result checker: sample settled outputs at the falling edge, act on the rising edge
  initial begin
    decoded_t exp_d;
    bit       take;
    forever begin
      @(negedge clk_i);
      take = rst_ni && out_valid_o && !out_stall_i;
      if (take) begin
        if (pending_instrs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got opcode %0h at %0h",
                   $time, opcode_value_o, instr_address_o);
        end else begin
          exp_d = pending_instrs.pop_front();
          check_field("instr_address", exp_d.addr, instr_address_o);
          check_field("opcode_value", exp_d.op, opcode_value_o);
          check_field("mnemonic_index", exp_d.mnem, mnemonic_index_o);
          check_field("mode_code", exp_d.mode, mode_code_o);
          check_field("instr_length", exp_d.len, instr_length_o);
          check_field("operand_value", exp_d.opnd, operand_value_o);
          check_field("branch_target", exp_d.target, branch_target_o);
          check_field("target_valid", exp_d.tvalid, target_valid_o);
          check_field("format_ok", exp_d.fmt_ok, format_ok_o);
        end
      end
      @(posedge clk_i);
    end
  end

  // length classes, branches with wrap, the odd [abs] form, field extremes
  task automatic test_directed();
    send_instr_opnd(8'hEA, 24'h000000, 0);         // implied, one byte
    send_instr_opnd(8'h00, 24'hFFFFFF, 24'hFF);    // brk at top of memory
    send_instr_opnd(8'h22, 24'h123456, 24'hFFFFFF); // long, all ones
    send_instr_opnd(8'h80, 24'h00FFFE, 24'h05);    // bra forward across 64k wrap
    send_instr_opnd(8'h80, 24'h000000, 24'h80);    // bra backward below zero
    send_instr_opnd(8'h82, 24'hABFFF0, 24'h7FFF);  // brl largest forward
    send_instr_opnd(8'h82, 24'h000010, 24'h8000);  // brl largest backward
    send_instr_opnd(8'h44, 24'h00C000, 24'h3412);  // block move
    send_instr_opnd(8'hDC, 24'h008000, 24'hBEEF);  // [abs] flagged as bad format
    send_instr_opnd(8'h6C, 24'h008003, 24'h1234);
    send_instr_opnd(8'hFF, 24'h555555, 24'hAAAAAA);
    send_instr_opnd(8'hA9, 24'hAAAAAA, 24'h55);    // imm with 8-bit accumulator
    send_instr_opnd(8'hA2, 24'h0F0F0F, 24'hF0);    // imm with 8-bit index
    drain();
  endtask

  // flags cleared, then flipped while an immediate is half way through
  task automatic test_flag_lengths();
    write_flag(ild_pkg::CfgAcc8, 1'b0);
    write_flag(ild_pkg::CfgIndex8, 1'b0);
    send_instr_opnd(8'h09, 24'h001000, 24'hCDAB);
    send_instr_opnd(8'hE0, 24'h001003, 24'h8001);
    send_byte(ild_pkg::OpLdaImm, 24'h002000);      // length fixed at 3 here
    drain();
    write_flag(ild_pkg::CfgAcc8, 1'b1);
    send_byte(8'h11, 24'h0);
    send_byte(8'h22, 24'h0);
    send_byte(ild_pkg::OpLdaImm, 24'h002003);      // now only 2
    send_byte(8'h33, 24'h0);
    drain();
    write_flag(ild_pkg::CfgIndex8, 1'b1);
  endtask

  // every opcode with wide immediates, then the flag-dependent ones under the other settings
  task automatic test_all_opcodes();
    for (int f = 0; f < 4; f++) begin
      write_flag(ild_pkg::CfgAcc8, f[0]);
      write_flag(ild_pkg::CfgIndex8, f[1]);
      for (int op = 0; op < 256; op++) begin
        if (f == 0 || is_flag_op(8'(op))) send_instr(8'(op), 24'($urandom));
      end
      drain();
    end
  endtask

  // random programs, mostly well formed with some raw byte noise, per phase of input idling and output stalls
  task automatic test_random_stream();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 80 : 0;
      stall_pct     = (ph == 2 || ph == 3) ? 80 : 0;
      if (ph == 3) begin
        send_idle_pct = 22;
        stall_pct     = 22;
      end
      write_flag(ild_pkg::CfgAcc8, 1'($urandom));
      write_flag(ild_pkg::CfgIndex8, 1'($urandom));
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(9) == 0) send_byte(8'($urandom), 24'($urandom));
        else send_instr(8'($urandom), 24'($urandom));
      end
      while (pos != 0) send_byte(8'($urandom), 24'($urandom));
      drain();
      stall_pct = 0;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = ild_pkg::CfgAcc8;
    cfg_data_i     = 1'b0;
    in_valid_i     = 1'b0;
    code_byte_i    = '0;
    byte_address_i = '0;
    out_stall_i    = 1'b0;
    m_flag         = 1'b1;
    x_flag         = 1'b1;
    pos            = 0;
    need_len       = '0;
    cur_op         = '0;
    cur_addr       = '0;
    cur_opnd       = '0;
    errors         = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_flag_lengths();
    send_idle_pct = 30;
    stall_pct     = 30;
    test_all_opcodes();
    test_random_stream();

    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
